// ===== src/assert_macros.svh =====
// Assertion macros of the Euler-to-quaternion block, used by euler_to_quaternion.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define E2Q_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define E2Q_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== src/e2q_pkg.sv =====
// Types and constants of the Euler-to-quaternion block.
// No dependencies; used by e2q_sincos and euler_to_quaternion.
package e2q_pkg;

    localparam int FIELD_BITS    = 16;  // width of every payload field
    localparam int ANGLE_BITS    = 16;  // full turn = 2^ANGLE_BITS, <= FIELD_BITS
    localparam int OUT_FRAC_BITS = 15;  // fraction bits of the results
    localparam int Q30_BITS      = 32;  // signed Q2.30 sine / cosine words
    localparam int CORDIC_BITS   = 34;  // CORDIC datapath, headroom over Q2.30
    localparam int ATAN_DEPTH    = 32;  // entries of the arctangent table

    localparam logic [31:0] PI_Q30          = 32'hC90F_DAA2;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD_3B6A;

    // atan(2^-i) in Q2.30
    localparam logic [31:0] ATAN_TAB [0:ATAN_DEPTH-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
        32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
    };

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] roll_angle;
        logic signed [FIELD_BITS-1:0] pitch_angle;
        logic signed [FIELD_BITS-1:0] yaw_angle;
    } t_euler_in;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] quat_w;
        logic signed [FIELD_BITS-1:0] quat_x;
        logic signed [FIELD_BITS-1:0] quat_y;
        logic signed [FIELD_BITS-1:0] quat_z;
    } t_quat_out;

endpackage

// ===== src/e2q_sincos.sv =====
// Half-angle sine/cosine lane: binary angle -> Q2.30 radians -> pipelined CORDIC.
// Depends on e2q_pkg. Takes one angle per cycle while i_en is high.
module e2q_sincos
    import e2q_pkg::*;
#(
    parameter int ITERATIONS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [FIELD_BITS-1:0] i_angle,
    output logic signed [Q30_BITS-1:0]  o_cos,
    output logic signed [Q30_BITS-1:0]  o_sin
);

    localparam int NS     = (ITERATIONS < ATAN_DEPTH) ? ITERATIONS : ATAN_DEPTH;
    localparam int MAG_W  = ANGLE_BITS + 1;
    localparam int PROD_W = MAG_W + 32;
    localparam int CW     = CORDIC_BITS;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ANGLE_BITS - 1);

    logic [MAG_W-1:0]  w_ext;
    logic [MAG_W-1:0]  w_mag;
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg;
    logic [CW-1:0]     w_zmag;
    logic [CW-1:0]     n_z0;

    logic signed [CW-1:0] c_x [0:NS];
    logic signed [CW-1:0] c_y [0:NS];
    logic signed [CW-1:0] n_x [0:NS-1];
    logic signed [CW-1:0] n_y [0:NS-1];
    logic signed [CW-1:0] n_z [0:NS-2];
    logic signed [CW-1:0] r_x [0:NS-1];
    logic signed [CW-1:0] r_y [0:NS-1];
    logic signed [CW-1:0] r_z [0:NS-1];

    // |angle| * pi, then round away from zero to Q2.30
    always_comb begin
        w_ext  = {i_angle[ANGLE_BITS-1], i_angle[ANGLE_BITS-1:0]};
        w_mag  = i_angle[ANGLE_BITS-1] ? (~w_ext + MAG_W'(1)) : w_ext;
        n_prod = PROD_W'(w_mag) * PROD_W'(PI_Q30);
        w_zmag = CW'((r_prod + ROUND_HALF) >> ANGLE_BITS);
        n_z0   = r_neg ? (~w_zmag + CW'(1)) : w_zmag;
    end

    // one rotation per stage; direction from the sign of the residual angle
    always_comb begin
        c_x[0] = CW'(CORDIC_GAIN_Q30);
        c_y[0] = '0;
        for (int i = 0; i < NS; i++) begin
            c_x[i+1] = r_x[i];
            c_y[i+1] = r_y[i];
        end
        for (int i = 0; i < NS; i++) begin
            if (!r_z[i][CW-1]) begin
                n_x[i] = c_x[i] - (c_y[i] >>> i);
                n_y[i] = c_y[i] + (c_x[i] >>> i);
            end else begin
                n_x[i] = c_x[i] + (c_y[i] >>> i);
                n_y[i] = c_y[i] - (c_x[i] >>> i);
            end
        end
        for (int i = 0; i < NS - 1; i++) begin
            if (!r_z[i][CW-1]) begin
                n_z[i] = r_z[i] - CW'(ATAN_TAB[i]);
            end else begin
                n_z[i] = r_z[i] + CW'(ATAN_TAB[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg  <= i_angle[ANGLE_BITS-1];
            r_prod <= n_prod;
            r_z[0] <= n_z0;
            for (int i = 0; i < NS; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
            end
            for (int i = 0; i < NS - 1; i++) begin
                r_z[i+1] <= n_z[i];
            end
        end
    end

    assign o_cos = r_x[NS-1][Q30_BITS-1:0];
    assign o_sin = r_y[NS-1][Q30_BITS-1:0];

endmodule

// ===== src/euler_to_quaternion.sv =====
// Euler angles (Z-Y-X order) to unit quaternion, top level.
// Depends on e2q_pkg, e2q_sincos and assert_macros.svh.
//
// Usage:
//   Input channel  i_valid / o_stall / i_data (roll, pitch, yaw binary angles,
//   full turn = 65536 LSB). A transfer happens on a clock edge with i_valid high
//   and o_stall low.
//   Output channel o_valid / i_stall / o_data (w, x, y, z in Q1.15, saturated so
//   +1.0 reads 32767). A transfer happens on an edge with o_valid high and
//   i_stall low.
//   Pipeline from input transfer to o_valid: the product register and the rounded
//   angle register scale the half angle to radians, one CORDIC stage per iteration
//   runs in each of three parallel lanes, P1 and P2 form the pair products and
//   round them, P3 and P4 form the terms and do the final round/saturate.
//   Throughput: one triple per cycle when not stalled; P1 has four multipliers, P3 eight.
//   Reset (i_rst_n low at a clock edge) empties the pipe: all valid bits clear,
//   data registers keep stale values that are never shown.
//   Stall: with the output register full and i_stall high, every stage holds and
//   o_stall goes high the same cycle; nothing is dropped or repeated.
`include "assert_macros.svh"

module euler_to_quaternion
    import e2q_pkg::*;
#(
    parameter int SINCOS_ITERATIONS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_euler_in i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_quat_out o_data
);

    localparam int NS        = (SINCOS_ITERATIONS < ATAN_DEPTH) ?
                               SINCOS_ITERATIONS : ATAN_DEPTH;
    localparam int LAT       = NS + 6;
    localparam int PROD_W    = 2 * Q30_BITS;
    localparam int SUM_W     = PROD_W + 1;
    localparam int OUT_SHIFT = 60 - OUT_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] PAIR_HALF = PROD_W'(1) << 29;
    localparam logic signed [SUM_W-1:0]  OUT_HALF  = SUM_W'(1) << (OUT_SHIFT - 1);
    localparam logic signed [SUM_W-1:0]  SAT_HI    = (SUM_W'(1) << OUT_FRAC_BITS) - 1;
    localparam logic signed [SUM_W-1:0]  SAT_LO    = -(SUM_W'(1) << OUT_FRAC_BITS);

    // Q60 sum -> OUT_FRAC_BITS, round half up, clamp to the signed range
    function automatic logic signed [FIELD_BITS-1:0] round_sat(
        input logic signed [SUM_W-1:0] s
    );
        logic signed [SUM_W-1:0] v;
        v = (s + OUT_HALF) >>> OUT_SHIFT;
        if (v > SAT_HI) begin
            return FIELD_BITS'(SAT_HI);
        end else if (v < SAT_LO) begin
            return FIELD_BITS'(SAT_LO);
        end
        return FIELD_BITS'(v);
    endfunction

    logic           w_en;       // whole pipe advances
    logic [LAT-1:0] r_vld;

    logic signed [Q30_BITS-1:0] w_cr, w_sr, w_cp, w_sp, w_cy, w_sy;

    // stage P1: raw pair products
    logic signed [PROD_W-1:0]   r_cpcy, r_spsy, r_spcy, r_cpsy;
    logic signed [Q30_BITS-1:0] r_cr1, r_sr1;
    // stage P2: pair products rounded to Q30
    logic signed [Q30_BITS-1:0] r_pcpcy, r_pspsy, r_pspcy, r_pcpsy;
    logic signed [Q30_BITS-1:0] r_cr2, r_sr2;
    // stage P3: the eight Q60 terms
    logic signed [PROD_W-1:0]   r_t_w0, r_t_w1, r_t_x0, r_t_x1;
    logic signed [PROD_W-1:0]   r_t_y0, r_t_y1, r_t_z0, r_t_z1;
    // stage P4: output register
    t_quat_out                  r_out;
    t_quat_out                  n_out;

    // pipe moves unless a finished result is held by the receiver
    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // three independent half-angle lanes
    e2q_sincos #(.ITERATIONS(NS)) u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_data.roll_angle),
        .o_cos   (w_cr),
        .o_sin   (w_sr)
    );

    e2q_sincos #(.ITERATIONS(NS)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_data.pitch_angle),
        .o_cos   (w_cp),
        .o_sin   (w_sp)
    );

    e2q_sincos #(.ITERATIONS(NS)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_data.yaw_angle),
        .o_cos   (w_cy),
        .o_sin   (w_sy)
    );

    // w = cr*cp*cy + sr*sp*sy   x = sr*cp*cy - cr*sp*sy
    // y = cr*sp*cy + sr*cp*sy   z = cr*cp*sy - sr*sp*cy
    always_comb begin
        n_out.quat_w = round_sat(SUM_W'(r_t_w0) + SUM_W'(r_t_w1));
        n_out.quat_x = round_sat(SUM_W'(r_t_x0) - SUM_W'(r_t_x1));
        n_out.quat_y = round_sat(SUM_W'(r_t_y0) + SUM_W'(r_t_y1));
        n_out.quat_z = round_sat(SUM_W'(r_t_z0) - SUM_W'(r_t_z1));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // P1
            r_cpcy  <= PROD_W'(w_cp) * PROD_W'(w_cy);
            r_spsy  <= PROD_W'(w_sp) * PROD_W'(w_sy);
            r_spcy  <= PROD_W'(w_sp) * PROD_W'(w_cy);
            r_cpsy  <= PROD_W'(w_cp) * PROD_W'(w_sy);
            r_cr1   <= w_cr;
            r_sr1   <= w_sr;
            // P2
            r_pcpcy <= Q30_BITS'((r_cpcy + PAIR_HALF) >>> 30);
            r_pspsy <= Q30_BITS'((r_spsy + PAIR_HALF) >>> 30);
            r_pspcy <= Q30_BITS'((r_spcy + PAIR_HALF) >>> 30);
            r_pcpsy <= Q30_BITS'((r_cpsy + PAIR_HALF) >>> 30);
            r_cr2   <= r_cr1;
            r_sr2   <= r_sr1;
            // P3
            r_t_w0  <= PROD_W'(r_cr2) * PROD_W'(r_pcpcy);
            r_t_w1  <= PROD_W'(r_sr2) * PROD_W'(r_pspsy);
            r_t_x0  <= PROD_W'(r_sr2) * PROD_W'(r_pcpcy);
            r_t_x1  <= PROD_W'(r_cr2) * PROD_W'(r_pspsy);
            r_t_y0  <= PROD_W'(r_cr2) * PROD_W'(r_pspcy);
            r_t_y1  <= PROD_W'(r_sr2) * PROD_W'(r_pcpsy);
            r_t_z0  <= PROD_W'(r_cr2) * PROD_W'(r_pcpsy);
            r_t_z1  <= PROD_W'(r_sr2) * PROD_W'(r_pspcy);
            // P4
            r_out   <= n_out;
        end
    end

    // input is only held back by a full, stalled output register
    `E2Q_ASSERT_ALWAYS(a_stall_needs_result, o_stall |-> (o_valid && i_stall), "stall without held result")
    // an accepted transfer enters the first stage
    `E2Q_ASSERT(a_accept_enters, (i_valid && !o_stall) |=> r_vld[0], "accepted transfer lost")
    // a held pipe keeps every valid bit
    `E2Q_ASSERT(a_hold_keeps_valids, o_stall |=> $stable(r_vld), "valid bits moved during stall")
    // a moving pipe feeds the output from the stage before it
    `E2Q_ASSERT(a_output_follows, !o_stall |=> (o_valid == $past(r_vld[LAT-2])), "output valid skipped a stage")

endmodule
